FILE: src/linear_convolution_top_assert.svh
// Assertion macros shared by the linear convolution checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef LINEAR_CONVOLUTION_TOP_ASSERT_SVH
`define LINEAR_CONVOLUTION_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LCT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset
`define LCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/lc_pkg.sv
// Shared types and constants for the linear convolution block.
// No dependencies; imported by lc_mac, lc_ctrl, the top level and the checker.
`timescale 1ns / 1ps

package lc_pkg;

  localparam int MAX_LEN   = 32;
  localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int SUM_W     = 37;
  localparam int IDX_W     = 6;
  localparam int CMD_W     = 2;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST  = 2'd0,
    CMD_SECOND = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic [ADDR_W-1:0]   raddr;
  } ram_ctl_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctl_t;

endpackage

FILE: src/lc_seq_ram.sv
// Single-port-write, single-port-read sample memory with registered read.
// Generic; depends on nothing but its parameters.
`timescale 1ns / 1ps

module lc_seq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lc_mac.sv
// Multiply-accumulate unit: registered product, then a 37-bit accumulator.
// Depends on lc_pkg.
`timescale 1ns / 1ps

module lc_mac import lc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  output logic signed [SUM_W-1:0]    acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [SUM_W-1:0]  acc_r;

  // Product stage
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.vld;
    end
  end

  // Accumulate stage; cleared at the start of every output index
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + SUM_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

FILE: src/lc_ctrl.sv
// Sequencer: sample loading, term walk over both memories, result register.
// Depends on lc_pkg.
`timescale 1ns / 1ps

module lc_ctrl import lc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  cmd_t                 in_cmd,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic [SUM_W-1:0]     acc,
  output ram_ctl_t             ram_a,
  output ram_ctl_t             ram_b,
  output mac_ctl_t             mac,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SUM_W-1:0]     out_sum,
  output logic [IDX_W-1:0]     out_idx,
  output logic                 out_last,
  output logic                 out_drop,
  output logic                 out_empty
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_a_r, cnt_b_r;
  logic                drop_r;
  logic [IDX_W-1:0]    k_r, i_r, i_hi_r;
  logic                rd_vld_r;
  logic                drain_r;
  logic                out_vld_r;
  logic [SUM_W-1:0]    out_sum_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r, out_empty_r, out_drop_r;

  logic                accept, out_free, out_load, issue;
  logic [IDX_W-1:0]    na_x, nb_x, n_last, i_lo, i_hi, j_idx;
  logic                is_empty, k_final;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign na_x     = IDX_W'(cnt_a_r);
  assign nb_x     = IDX_W'(cnt_b_r);
  assign is_empty = (cnt_a_r == '0) || (cnt_b_r == '0);
  assign n_last   = na_x + nb_x - IDX_W'(2);
  assign k_final  = (k_r == n_last);
  assign j_idx    = k_r - i_r;

  // Term range of index k: i from max(0, k-nb+1) to min(k, na-1)
  assign i_lo = (k_r >= nb_x) ? (k_r - nb_x + IDX_W'(1)) : '0;
  assign i_hi = (k_r < na_x) ? k_r : (na_x - IDX_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_RUN) begin
          state_nxt = is_empty ? ST_EMPTY : ST_SETUP;
        end
      end
      ST_EMPTY: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_SETUP: state_nxt = ST_MAC;
      ST_MAC: begin
        if (i_r == i_hi_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_r) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = k_final ? ST_IDLE : ST_SETUP;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready   = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    mac.clr     = 1'b0;
    ram_a.we    = 1'b0;
    ram_b.we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_a.we  = accept && (in_cmd == CMD_FIRST) && (cnt_a_r < CNT_W'(MAX_LEN));
        ram_b.we  = accept && (in_cmd == CMD_SECOND) && (cnt_b_r < CNT_W'(MAX_LEN));
      end
      ST_EMPTY: out_load = out_free;
      ST_SETUP: mac.clr  = 1'b1;
      ST_MAC:   issue    = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  out_load = out_free;
      default: ;
    endcase
    ram_a.waddr = cnt_a_r[ADDR_W-1:0];
    ram_b.waddr = cnt_b_r[ADDR_W-1:0];
    ram_a.wdata = in_sample;
    ram_b.wdata = in_sample;
    ram_a.raddr = i_r[ADDR_W-1:0];
    ram_b.raddr = j_idx[ADDR_W-1:0];
    mac.vld     = rd_vld_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      drop_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      drain_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      // Count appends, flag the ones past a full sequence
      if (accept && in_cmd == CMD_FIRST) begin
        if (ram_a.we) cnt_a_r <= cnt_a_r + CNT_W'(1);
        else          drop_r  <= 1'b1;
      end
      if (accept && in_cmd == CMD_SECOND) begin
        if (ram_b.we) cnt_b_r <= cnt_b_r + CNT_W'(1);
        else          drop_r  <= 1'b1;
      end
      // Pipeline drain after the last issued term, timed by drain_r
      if (state_r == ST_DRAIN) drain_r <= !drain_r;
      // Clear both sequences once the final result of the run is loaded for output
      if (out_load && (state_r == ST_EMPTY || k_final)) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
      end
      if (out_load)        out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // Term walk and result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      k_r <= '0;
    end else if (state_r == ST_EMIT && out_free) begin
      k_r <= k_r + IDX_W'(1);
    end
    if (state_r == ST_SETUP) begin
      i_r    <= i_lo;
      i_hi_r <= i_hi;
    end else if (issue) begin
      i_r <= i_r + IDX_W'(1);
    end
    if (out_load) begin
      out_empty_r <= (state_r == ST_EMPTY);
      out_sum_r   <= (state_r == ST_EMPTY) ? '0 : acc;
      out_idx_r   <= (state_r == ST_EMPTY) ? '0 : k_r;
      out_last_r  <= (state_r == ST_EMPTY) || k_final;
      out_drop_r  <= drop_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_sum    = out_sum_r;
  assign out_idx    = out_idx_r;
  assign out_last   = out_last_r;
  assign out_drop   = out_drop_r;
  assign out_empty  = out_empty_r;

endmodule

FILE: src/linear_convolution_top.sv
// Top level of the linear convolution block: two sample memories, MAC, sequencer.
// Depends on lc_pkg, lc_seq_ram, lc_mac and lc_ctrl.
`timescale 1ns / 1ps

// Loads two sequences of up to 32 signed 16-bit samples (tuser 0 or 1;
// samples past a full sequence are dropped and a sticky flag is raised) and
// on a run (tuser 2) streams the exact linear convolution, one 37-bit sum
// per output transaction, tlast on the final one, then clears both
// sequences. A run with an empty sequence gives one zero sum marked empty.
// One sample pair is read from the two memories per cycle and fed through the
// two-stage multiply-accumulate, one pair per term of the output. The input
// stalls while a run is in progress; the last result is held in an output
// register so loading can resume right away.
module linear_convolution_top import lc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic [CMD_W-1:0]      in_tuser,   // [1:0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [36:0] sum_value, [42:37] out_index
  output logic                  out_tlast,  // last_sum
  output logic [OUT_USER_W-1:0] out_tuser   // [0] samples_dropped, [1] empty_run
);

  ram_ctl_t            ram_a, ram_b;
  mac_ctl_t            mac;
  logic [SAMPLE_W-1:0] rd_a, rd_b;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    out_sum;
  logic [IDX_W-1:0]    out_idx;
  logic                out_drop, out_empty;

  // Sample memories
  lc_seq_ram #(.DEPTH(MAX_LEN), .WIDTH(SAMPLE_W)) u_ram_a (
    .clk   (clk),
    .we    (ram_a.we),
    .waddr (ram_a.waddr),
    .wdata (ram_a.wdata),
    .raddr (ram_a.raddr),
    .rdata (rd_a)
  );

  lc_seq_ram #(.DEPTH(MAX_LEN), .WIDTH(SAMPLE_W)) u_ram_b (
    .clk   (clk),
    .we    (ram_b.we),
    .waddr (ram_b.waddr),
    .wdata (ram_b.wdata),
    .raddr (ram_b.raddr),
    .rdata (rd_b)
  );

  // Multiply-accumulate
  lc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac),
    .a     (rd_a),
    .b     (rd_b),
    .acc   (acc)
  );

  // Sequencer
  lc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (cmd_t'(in_tuser)),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .acc        (acc),
    .ram_a      (ram_a),
    .ram_b      (ram_b),
    .mac        (mac),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sum    (out_sum),
    .out_idx    (out_idx),
    .out_last   (out_tlast),
    .out_drop   (out_drop),
    .out_empty  (out_empty)
  );

  // Pack the result transaction
  assign out_tdata = {{(OUT_DATA_W - SUM_W - IDX_W){1'b0}}, out_idx, out_sum};
  assign out_tuser = {out_empty, out_drop};

endmodule

FILE: src/lc_checker.sv
// Port-level checker for linear_convolution_top, bound to every instance.
// Depends on lc_pkg and linear_convolution_top_assert.svh.
`timescale 1ns / 1ps
`include "linear_convolution_top_assert.svh"

module lc_checker import lc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [CMD_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // A waiting result transaction holds its payload
  `LCT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser),
    "result changed while stalled")

  // A run blocks the input for at least the next cycle
  `LCT_ASSERT_NEXT(a_run_blocks, in_tvalid && in_tready && in_tuser == CMD_RUN,
    !in_tready, "input taken right after a run")

  // An empty run is a single final result
  `LCT_ASSERT_NOW(a_empty_last, out_tvalid && out_tuser[1], out_tlast,
    "empty result without last mark")

  // An empty run carries a zero sum at index zero
  `LCT_ASSERT_NOW(a_empty_zero, out_tvalid && out_tuser[1], out_tdata == '0,
    "empty result with nonzero payload")

endmodule

bind linear_convolution_top lc_checker u_lc_checker (.*);
